@@ src/ptd_pkg.sv @@
package ptd_pkg;

	localparam int NUMBER_BITS_DEF = 31;
	localparam int STEP_BITS       = 4;

	typedef enum logic [STEP_BITS-1:0] {
		S_IDLE  = 4'd0,
		S_SMALL = 4'd1,
		S_DIV   = 4'd2,
		S_WAIT  = 4'd3,
		S_BOUND = 4'd4,
		S_COUNT = 4'd5,
		S_TEST  = 4'd6,
		S_LOOP  = 4'd7,
		S_PRIME = 4'd8,
		S_COMP  = 4'd9
	} step_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_START,
		OP_COUNT,
		OP_INC,
		OP_EMIT_PRIME,
		OP_EMIT_COMP
	} op_t;

	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_IN_VALID,
		C_LE1,
		C_DIV_DONE,
		C_D_GT_Q,
		C_FOUND_GT2,
		C_OUT_FREE
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
		logic  stay;
	} ctrl_t;

	typedef struct packed {
		logic in_valid;
		logic le1;
		logic div_done;
		logic d_gt_q;
		logic found_gt2;
		logic out_free;
	} stat_t;

	function automatic ctrl_t microcode(input step_t step);
		ctrl_t w;
		w = '{op: OP_NONE, cond: C_NEVER, target: S_IDLE, stay: 1'b0};
		unique case (step)
			S_IDLE:  w = '{op: OP_LOAD,       cond: C_IN_VALID,  target: S_SMALL, stay: 1'b1};
			S_SMALL: w = '{op: OP_NONE,       cond: C_LE1,       target: S_COMP,  stay: 1'b0};
			S_DIV:   w = '{op: OP_START,      cond: C_NEVER,     target: S_IDLE,  stay: 1'b0};
			S_WAIT:  w = '{op: OP_NONE,       cond: C_DIV_DONE,  target: S_BOUND, stay: 1'b1};
			S_BOUND: w = '{op: OP_NONE,       cond: C_D_GT_Q,    target: S_PRIME, stay: 1'b0};
			S_COUNT: w = '{op: OP_COUNT,      cond: C_NEVER,     target: S_IDLE,  stay: 1'b0};
			S_TEST:  w = '{op: OP_INC,        cond: C_FOUND_GT2, target: S_COMP,  stay: 1'b0};
			S_LOOP:  w = '{op: OP_NONE,       cond: C_ALWAYS,    target: S_DIV,   stay: 1'b0};
			S_PRIME: w = '{op: OP_EMIT_PRIME, cond: C_OUT_FREE,  target: S_IDLE,  stay: 1'b1};
			S_COMP:  w = '{op: OP_EMIT_COMP,  cond: C_OUT_FREE,  target: S_IDLE,  stay: 1'b1};
			default: w = '{op: OP_NONE,       cond: C_ALWAYS,    target: S_IDLE,  stay: 1'b0};
		endcase
		return w;
	endfunction

endpackage

@@ src/primality_test_trial_division_top.sv @@
// Zero and one are answered without the divider; otherwise the sequencer tries divisors
// one after another; the number of trial divisors is up to floor(sqrt(number)) + 1.
// One request at a time; each divisor costs one wait on the bit-serial divider plus five
// microcode steps around it.
// Reset clears the step counter, the divider and the output valid flag asynchronously.
module primality_test_trial_division_top import ptd_pkg::*; #(
	parameter int NUMBER_BITS = NUMBER_BITS_DEF,
	parameter int IN_BYTES_W  = ((NUMBER_BITS + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_BYTES_W-1:0] s_tdata,  // number
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [7:0]            m_tdata   // is_prime
);

	ctrl_t                  ctrl;
	stat_t                  stat;
	logic                   div_start;
	logic                   div_done;
	logic [NUMBER_BITS-1:0] div_dividend;
	logic [NUMBER_BITS-1:0] div_divisor;
	logic [NUMBER_BITS-1:0] div_quotient;
	logic [NUMBER_BITS-1:0] div_remainder;

	ptd_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	ptd_datapath #(
		.NUMBER_BITS (NUMBER_BITS),
		.IN_BYTES_W  (IN_BYTES_W)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.stat          (stat),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.div_start     (div_start),
		.div_dividend  (div_dividend),
		.div_divisor   (div_divisor),
		.div_done      (div_done),
		.div_quotient  (div_quotient),
		.div_remainder (div_remainder)
	);

	ptd_divider #(
		.NUMBER_BITS (NUMBER_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quotient),
		.remainder (div_remainder)
	);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("new request taken while one is in progress");

	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result raised while the sequencer was idle");

	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (div_divisor != '0) && div_done)
		else $error("divider started with zero divisor or while busy");

endmodule

@@ src/ptd_divider.sv @@
module ptd_divider import ptd_pkg::*; #(
	parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [NUMBER_BITS-1:0] dividend,
	input  logic [NUMBER_BITS-1:0] divisor,
	output logic                   done,
	output logic [NUMBER_BITS-1:0] quotient,
	output logic [NUMBER_BITS-1:0] remainder
);

	localparam int CNT_BITS = $clog2(NUMBER_BITS + 1);

	logic                   busy_q;
	logic [CNT_BITS-1:0]    cnt_q;
	logic [NUMBER_BITS-1:0] quo_q;
	logic [NUMBER_BITS-1:0] rem_q;
	logic [NUMBER_BITS-1:0] divs_q;
	logic [NUMBER_BITS:0]   shifted;
	logic [NUMBER_BITS:0]   diff;
	logic                   ge;

	assign shifted = {rem_q, quo_q[NUMBER_BITS-1]};
	assign diff    = shifted - {1'b0, divs_q};
	assign ge      = ~diff[NUMBER_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_BITS'(NUMBER_BITS);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - CNT_BITS'(1);
			busy_q <= (cnt_q != CNT_BITS'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q  <= dividend;
			rem_q  <= '0;
			divs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[NUMBER_BITS-1:0] : shifted[NUMBER_BITS-1:0];
			quo_q <= {quo_q[NUMBER_BITS-2:0], ge};
		end
	end

	assign done      = ~busy_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

@@ src/ptd_sequencer.sv @@
module ptd_sequencer import ptd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  stat_t stat,
	output ctrl_t ctrl
);

	step_t pc_q;
	step_t pc_d;
	logic  taken;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= S_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

	always_comb begin
		ctrl = microcode(pc_q);
		unique case (ctrl.cond)
			C_NEVER:     taken = 1'b0;
			C_ALWAYS:    taken = 1'b1;
			C_IN_VALID:  taken = stat.in_valid;
			C_LE1:       taken = stat.le1;
			C_DIV_DONE:  taken = stat.div_done;
			C_D_GT_Q:    taken = stat.d_gt_q;
			C_FOUND_GT2: taken = stat.found_gt2;
			C_OUT_FREE:  taken = stat.out_free;
			default:     taken = 1'b1;
		endcase
		if (taken) begin
			pc_d = ctrl.target;
		end else if (ctrl.stay) begin
			pc_d = pc_q;
		end else begin
			pc_d = step_t'(STEP_BITS'(pc_q + STEP_BITS'(1)));
		end
	end

endmodule

@@ src/ptd_datapath.sv @@
module ptd_datapath import ptd_pkg::*; #(
	parameter int NUMBER_BITS = NUMBER_BITS_DEF,
	parameter int IN_BYTES_W  = ((NUMBER_BITS + 7) / 8) * 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ctrl_t                  ctrl,
	output stat_t                  stat,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_BYTES_W-1:0]  s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [7:0]             m_tdata,
	output logic                   div_start,
	output logic [NUMBER_BITS-1:0] div_dividend,
	output logic [NUMBER_BITS-1:0] div_divisor,
	input  logic                   div_done,
	input  logic [NUMBER_BITS-1:0] div_quotient,
	input  logic [NUMBER_BITS-1:0] div_remainder
);

	logic [NUMBER_BITS-1:0] n_q;
	logic [NUMBER_BITS-1:0] d_q;
	logic [2:0]             found_q;
	logic                   out_valid_q;
	logic                   out_prime_q;
	logic                   out_free;
	logic                   emit;

	assign s_tready = (ctrl.op == OP_LOAD);
	assign out_free = ~out_valid_q | m_tready;
	assign emit     = out_free & ((ctrl.op == OP_EMIT_PRIME) | (ctrl.op == OP_EMIT_COMP));

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			n_q     <= s_tdata[NUMBER_BITS-1:0];
			d_q     <= NUMBER_BITS'(1);
			found_q <= '0;
		end else if (ctrl.op == OP_COUNT) begin
			if (div_remainder == '0) begin
				found_q <= found_q + ((div_quotient != d_q) ? 3'd2 : 3'd1);
			end
		end else if (ctrl.op == OP_INC) begin
			d_q <= d_q + NUMBER_BITS'(1);
		end
		if (emit) begin
			out_prime_q <= (ctrl.op == OP_EMIT_PRIME);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign stat.in_valid  = s_tvalid;
	assign stat.le1       = (n_q[NUMBER_BITS-1:1] == '0);
	assign stat.div_done  = div_done;
	assign stat.d_gt_q    = (d_q > div_quotient);
	assign stat.found_gt2 = (found_q > 3'd2);
	assign stat.out_free  = out_free;

	assign div_start    = (ctrl.op == OP_START);
	assign div_dividend = n_q;
	assign div_divisor  = d_q;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_prime_q};

endmodule

@@ dv/prime_flag_check.sv @@
`timescale 1ns / 100ps

module prime_flag_check import ptd_pkg::*; #(
	parameter int NUM_W = NUMBER_BITS_DEF,
	parameter int IN_W  = ((NUM_W + 7) / 8) * 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	input  logic            s_tready,
	input  logic [IN_W-1:0] s_tdata,
	input  logic            m_tvalid,
	input  logic            m_tready,
	input  logic [7:0]      m_tdata,
	output int              fail_count,
	output int              pending
);

	typedef struct packed {
		logic [NUM_W-1:0] number;
		logic             is_prime;
	} verdict_t;

	verdict_t verdict_q [$];

	function automatic logic trial_division_prime(input longint unsigned value);
		longint unsigned divisor;
		int unsigned     found;
		found = 0;
		if (value <= 1) return 1'b0;
		for (divisor = 1; divisor <= value / divisor; divisor++) begin
			if (value % divisor == 0) found += (value / divisor != divisor) ? 2 : 1;
			if (found > 2) return 1'b0;
		end
		return 1'b1;
	endfunction

	// A result can never leave on the same edge that its own request enters,
	// so the result side is handled first.
	always @(posedge clk) begin
		verdict_t want;
		logic [NUM_W-1:0] number;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (verdict_q.size() == 0) begin
					$display("%0t: result %0d with no request outstanding", $time, m_tdata);
					fail_count++;
				end else begin
					want = verdict_q.pop_front();
					if (m_tdata !== {7'b0, want.is_prime}) begin
						$display("%0t: is_prime mismatch for %0d, expected %0d, got %0d",
							$time, want.number, want.is_prime, m_tdata);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				number = s_tdata[NUM_W-1:0];
				verdict_q.push_back('{number: number, is_prime: trial_division_prime(number)});
			end
			pending = verdict_q.size();
		end
	end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps

module tb;
	import ptd_pkg::*;

	localparam int NUM_W       = NUMBER_BITS_DEF;
	localparam int IN_W        = ((NUM_W + 7) / 8) * 8;
	localparam int HOLD_CYCLES = 3000;
	localparam int PHASE_ITEMS = 18;

	logic            clk      = 1'b0;
	logic            arst_n   = 1'b0;
	logic            s_tvalid = 1'b0;
	logic            s_tready;
	logic [IN_W-1:0] s_tdata  = '0;
	logic            m_tvalid;
	logic            m_tready = 1'b0;
	logic [7:0]      m_tdata;

	int fail_count;
	int pending;
	int idle_pct   = 0;
	int stall_pct  = 0;
	int hold_count = 0;
	bit long_hold  = 1'b0;
	bit hold_done  = 1'b0;

	int unsigned corner_numbers [25] = '{
		0, 1, 2, 3, 4, 5, 6, 8, 9, 25, 49, 97, 121, 1021, 65521, 65537, 999983,
		1073741823, 1073741824, 715827882, 1431655765, 2147395600, 2147483645,
		2147483646, 2147483647
	};

	primality_test_trial_division_top #(.NUMBER_BITS(NUM_W)) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	prime_flag_check #(.NUM_W(NUM_W), .IN_W(IN_W)) u_prime_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// The long hold-off keeps the output closed until hold_done is set.
	always @(negedge clk) begin
		if (long_hold && !hold_done) begin
			m_tready = 1'b0;
			hold_count++;
			if (hold_count == HOLD_CYCLES) hold_done = 1'b1;
		end else begin
			if (!long_hold) begin
				hold_count = 0;
				hold_done  = 1'b0;
			end
			m_tready = ($urandom_range(99) >= stall_pct);
		end
	end

	// Random numbers stay small most of the time, since a prime costs one
	// divider pass per candidate up to its square root. Full-width values are
	// multiples of three so that they resolve after a few divisors.
	function automatic logic [NUM_W-1:0] pick_number();
		int unsigned kind;
		int unsigned root;
		kind = $urandom_range(99);
		root = $urandom_range(200, 2);
		if (kind < 45) return NUM_W'($urandom_range(1023));
		if (kind < 65) return NUM_W'($urandom_range(65535));
		if (kind < 75) return NUM_W'(root * root);
		if (kind < 85) return NUM_W'($urandom_range(1048575));
		return NUM_W'(3 * $urandom_range(715827882));
	endfunction

	task automatic send_number(input logic [NUM_W-1:0] number);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = IN_W'(number);
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic wait_for_results();
		s_tvalid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	initial begin
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (corner_numbers[i]) send_number(NUM_W'(corner_numbers[i]));
		wait_for_results();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					idle_pct  = 0;
					stall_pct = 0;
					long_hold = 1'b1;
					repeat (6) send_number(NUM_W'($urandom_range(200)));
					s_tvalid = 1'b0;
					while (!hold_done) @(negedge clk);
					long_hold = 1'b0;
				end
				1: begin
					idle_pct  = 52;
					stall_pct = 0;
				end
				2: begin
					idle_pct  = 0;
					stall_pct = 52;
				end
				default: begin
					idle_pct  = 28;
					stall_pct = 28;
				end
			endcase
			repeat (PHASE_ITEMS) send_number(pick_number());
			wait_for_results();
		end

		repeat (50) @(negedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#160000000;
		$display("Some tests failed");
		$finish;
	end

endmodule

@@ files.f @@
src/ptd_pkg.sv
src/ptd_divider.sv
src/ptd_sequencer.sv
src/ptd_datapath.sv
src/primality_test_trial_division_top.sv
dv/prime_flag_check.sv
dv/tb.sv
